FILE: src/space_vector_pwm_timing_defines.svh
// ----------------------------------------------------------------------------
// Space vector PWM timing - assertion macros
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_TIMING_DEFINES_SVH
`define SPACE_VECTOR_PWM_TIMING_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define SVPWM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define SVPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define SVPWM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - package
// Types and fixed constants shared by the front, queue, back and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    localparam int SECTOR_COUNT  = 6;
    localparam int MATRIX_SLOTS  = 4;
    localparam int ROW_W         = $clog2(SECTOR_COUNT);
    localparam int SLOT_W        = $clog2(MATRIX_SLOTS);

    localparam logic [15:0] PERIOD_RESET = 16'd1250;

    // Sector thresholds, Q3.13 radians
    localparam logic signed [15:0] ANGLE_60      = 16'sd8577;
    localparam logic signed [15:0] ANGLE_120     = 16'sd17154;
    localparam logic signed [15:0] ANGLE_NEG_60  = -16'sd8577;
    localparam logic signed [15:0] ANGLE_NEG_120 = -16'sd17154;
    localparam logic signed [15:0] ANGLE_ZERO    = 16'sd0;

    // Datapath widths
    localparam int PROD_W  = 32;  // Q1.14 x Q2.14 product
    localparam int TSUM_W  = 33;  // T1 / T2
    localparam int ON_W    = 34;  // twice the on-time, Q.28
    localparam int SCALE_W = 51;  // on-time times period
    localparam int ROUND_W = 52;  // scaled value plus rounding constant
    localparam int FRAC_SH = 29;

    localparam logic signed [ON_W-1:0]    ONE_Q28   = 34'sd268435456;
    localparam logic signed [ROUND_W-1:0] HALF_LSB  = 52'sd268435456;

    typedef enum logic
    {
        CMD_WRITE    = 1'b0,
        CMD_MODULATE = 1'b1
    } cmd_e;

    typedef enum logic [ROW_W-1:0]
    {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_e;

    // One classified entry of the work queue
    typedef struct packed
    {
        logic               is_write;
        logic               write_ok;     // table index in range
        logic [SLOT_W-1:0]  slot;         // column: low two bits of the table index
        logic [ROW_W-1:0]   row;          // sector: write target or lookup
        logic signed [15:0] coefficient;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } queue_item_t;

endpackage

`default_nettype wire

FILE: src/svpwm_ifs.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - channel interfaces
// Valid/ready channels for the input items and the compare results.
// ----------------------------------------------------------------------------
`default_nettype none

interface svpwm_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [4:0]         table_index;
    logic signed [15:0] coefficient;
    logic signed [15:0] angle;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;

    modport source (output valid, command, table_index, coefficient, angle, alpha, beta,
                    input ready);
    modport sink   (input valid, command, table_index, coefficient, angle, alpha, beta,
                    output ready);
endinterface

interface svpwm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [2:0]  sector;
    logic        saturated;

    modport source (output valid, compare_a, compare_b, compare_c, sector, saturated,
                    input ready);
    modport sink   (input valid, compare_a, compare_b, compare_c, sector, saturated,
                    output ready);
endinterface

`default_nettype wire

FILE: src/svpwm_front.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - front end
// Classify each input transaction and find the sector of a modulate item.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_front
    import svpwm_pkg::*;
(
    svpwm_in_if.sink    items,
    input  logic        push_ready,
    output logic        push_valid,
    output queue_item_t push_item
);

    sector_e sector;
    logic    is_write;

    // Clamping the angle to plus or minus pi never moves it across a threshold,
    // so compare the raw angle.
    always_comb
    begin
        if (items.angle < ANGLE_NEG_120)
            sector = SEC_3;
        else if (items.angle < ANGLE_NEG_60)
            sector = SEC_4;
        else if (items.angle <= ANGLE_ZERO)
            sector = SEC_5;
        else if (items.angle < ANGLE_60)
            sector = SEC_0;
        else if (items.angle < ANGLE_120)
            sector = SEC_1;
        else
            sector = SEC_2;
    end

    assign is_write = (cmd_e'(items.command) == CMD_WRITE);

    always_comb
    begin
        push_item.is_write    = is_write;
        push_item.write_ok    = (items.table_index[4:3] != 2'b11);
        push_item.slot        = items.table_index[SLOT_W-1:0];
        push_item.row         = is_write ? items.table_index[4:2] : ROW_W'(sector);
        push_item.coefficient = items.coefficient;
        push_item.alpha       = items.alpha;
        push_item.beta        = items.beta;
    end

    assign push_valid  = items.valid;
    assign items.ready = push_ready;

endmodule

`default_nettype wire

FILE: src/svpwm_queue.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - work queue
// Small FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_queue
    import svpwm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  queue_item_t push_item,
    output logic        push_ready,
    output logic        pop_valid,
    input  logic        pop_ready,
    output queue_item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: src/svpwm_back.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - back end
// Own the sector matrix, run the five-stage on-time datapath, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_back
    import svpwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  queue_item_t pop_item,
    output logic        pop_ready,
    input  logic [15:0] period,
    svpwm_out_if.source compares
);

    // Sector matrix: one bank per coefficient slot, addressed by sector
    logic signed [15:0] bank_mem [MATRIX_SLOTS][SECTOR_COUNT];

    logic advance, pop;

    // Stage 1: matrix read
    logic                     s1_valid_reg;
    logic signed [15:0]       s1_m_reg [MATRIX_SLOTS];
    logic signed [15:0]       s1_alpha_reg, s1_beta_reg;
    sector_e                  s1_sector_reg;
    // Stage 2: products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_p_reg [MATRIX_SLOTS];
    sector_e                  s2_sector_reg;
    // Stage 3: T1, T2
    logic                     s3_valid_reg;
    logic signed [TSUM_W-1:0] s3_t1_reg, s3_t2_reg;
    sector_e                  s3_sector_reg;
    // Stage 4: permuted on-times
    logic                     s4_valid_reg;
    logic signed [ON_W-1:0]   s4_on_reg [3];
    logic signed [ON_W-1:0]   s4_on_next [3];
    sector_e                  s4_sector_reg;
    // Stage 5: scaled by period
    logic                      s5_valid_reg;
    logic signed [SCALE_W-1:0] s5_scaled_reg [3];
    sector_e                   s5_sector_reg;
    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [15:0]               out_cmp_reg [3];
    logic [15:0]               out_cmp_next [3];
    logic                      out_sat_reg, out_sat_next;
    sector_e                   out_sector_reg;

    logic signed [ON_W-1:0]    ta, tb, tc;
    logic signed [ROUND_W-1:0] rounded [3];
    logic [ROUND_W-FRAC_SH-1:0] whole [3];

    // The whole pipe moves when the result register is free or being taken
    assign advance   = !out_valid_reg || compares.ready;
    assign pop_ready = advance;
    assign pop       = pop_valid && advance;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < MATRIX_SLOTS; k++)
            begin
                if (pop_item.is_write && pop_item.write_ok && pop_item.slot == SLOT_W'(k))
                    bank_mem[k][pop_item.row] <= pop_item.coefficient;
                s1_m_reg[k] <= bank_mem[k][pop_item.row];
            end
            s1_alpha_reg  <= pop_item.alpha;
            s1_beta_reg   <= pop_item.beta;
            s1_sector_reg <= sector_e'(pop_item.row);
        end
    end

    // On-times, twice scaled, Q.28
    always_comb
    begin
        ta = ONE_Q28 - ON_W'(s3_t1_reg) - ON_W'(s3_t2_reg);
        tb = ONE_Q28 + ON_W'(s3_t1_reg) - ON_W'(s3_t2_reg);
        tc = ONE_Q28 + ON_W'(s3_t1_reg) + ON_W'(s3_t2_reg);
        case (s3_sector_reg)
            SEC_0:
            begin
                s4_on_next[0] = ta; s4_on_next[1] = tb; s4_on_next[2] = tc;
            end
            SEC_1:
            begin
                s4_on_next[0] = tb; s4_on_next[1] = ta; s4_on_next[2] = tc;
            end
            SEC_2:
            begin
                s4_on_next[0] = tc; s4_on_next[1] = ta; s4_on_next[2] = tb;
            end
            SEC_3:
            begin
                s4_on_next[0] = tc; s4_on_next[1] = tb; s4_on_next[2] = ta;
            end
            SEC_4:
            begin
                s4_on_next[0] = tb; s4_on_next[1] = tc; s4_on_next[2] = ta;
            end
            default:
            begin
                s4_on_next[0] = ta; s4_on_next[1] = tc; s4_on_next[2] = tb;
            end
        endcase
    end

    // Round half up, then clamp to 0..period
    always_comb
    begin
        out_sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rounded[i] = ROUND_W'(s5_scaled_reg[i]) + HALF_LSB;
            whole[i]   = rounded[i][ROUND_W-1:FRAC_SH];
            if (rounded[i][ROUND_W-1])
            begin
                out_cmp_next[i] = '0;
                out_sat_next    = 1'b1;
            end
            else if (whole[i] > (ROUND_W-FRAC_SH)'(period))
            begin
                out_cmp_next[i] = period;
                out_sat_next    = 1'b1;
            end
            else
                out_cmp_next[i] = whole[i][15:0];
        end
    end

    assign out_valid_next = advance ? s5_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_p_reg[0]   <= PROD_W'(s1_alpha_reg) * PROD_W'(s1_m_reg[0]);
            s2_p_reg[1]   <= PROD_W'(s1_beta_reg)  * PROD_W'(s1_m_reg[1]);
            s2_p_reg[2]   <= PROD_W'(s1_alpha_reg) * PROD_W'(s1_m_reg[2]);
            s2_p_reg[3]   <= PROD_W'(s1_beta_reg)  * PROD_W'(s1_m_reg[3]);
            s2_sector_reg <= s1_sector_reg;

            s3_t1_reg     <= TSUM_W'(s2_p_reg[0]) + TSUM_W'(s2_p_reg[1]);
            s3_t2_reg     <= TSUM_W'(s2_p_reg[2]) + TSUM_W'(s2_p_reg[3]);
            s3_sector_reg <= s2_sector_reg;

            s4_on_reg     <= s4_on_next;
            s4_sector_reg <= s3_sector_reg;

            for (int i = 0; i < 3; i++)
                s5_scaled_reg[i] <= SCALE_W'(s4_on_reg[i]) * SCALE_W'($signed({1'b0, period}));
            s5_sector_reg <= s4_sector_reg;

            out_cmp_reg    <= out_cmp_next;
            out_sat_reg    <= out_sat_next;
            out_sector_reg <= s5_sector_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= pop && !pop_item.is_write;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign compares.valid     = out_valid_reg;
    assign compares.compare_a = out_cmp_reg[0];
    assign compares.compare_b = out_cmp_reg[1];
    assign compares.compare_c = out_cmp_reg[2];
    assign compares.sector    = 3'(out_sector_reg);
    assign compares.saturated = out_sat_reg;

endmodule

`default_nettype wire

FILE: src/space_vector_pwm_timing.sv
// A modulate item is registered in the queue, each back-end stage and the output.
// Throughput: one transaction per cycle unless compares stall; single-issue back end.
// A write transaction takes one queue slot and a back-end pop but yields no result.
// Reset (rst_n low, asynchronous) empties the queue and pipeline, period 1250.
// The sector matrix is not cleared; each entry must be written before use.
// ----------------------------------------------------------------------------
// Space vector PWM timing - top level
// Two-level SVPWM compare generator with a loadable per-sector matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_timing
    import svpwm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    svpwm_in_if.sink    items,
    svpwm_out_if.source compares
);

    // Period register: the user must write it only while the block is idle,
    // which the block does not enforce, so that every stage may read it directly.
    logic [15:0] period_reg;

    logic        push_valid, push_ready;
    queue_item_t push_item;
    logic        pop_valid, pop_ready;
    queue_item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    // Front end: classify each transaction as a matrix write or a modulate
    // request and resolve the sector from the angle, so the queue carries the
    // matrix row that the back end must touch.
    svpwm_front u_front
    (
        .items      (items),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // Queue: lets the front keep accepting while a result waits downstream.
    svpwm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: matrix writes and reads happen in queue order at the pop, so a
    // modulate item always sees every write that was accepted before it.
    // Stages: matrix read, four products, T1/T2, on-times and phase permute,
    // period scaling, then round and clamp into the result register.
    svpwm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .period    (period_reg),
        .compares  (compares)
    );

endmodule

`default_nettype wire

FILE: src/svpwm_checker.sv
// ----------------------------------------------------------------------------
// Space vector PWM timing - port checker
// Watch the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "space_vector_pwm_timing_defines.svh"

module svpwm_checker
    import svpwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] compare_a,
    input  logic [15:0] compare_b,
    input  logic [15:0] compare_c,
    input  logic [2:0]  sector,
    input  logic        saturated
);

    // Mirror the period as seen on the configuration port
    logic [15:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    `SVPWM_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(compare_a) && $stable(compare_b) && $stable(compare_c)
            && $stable(sector) && $stable(saturated),
        "result changed while stalled")
    `SVPWM_ASSERT_IMPLY(a_compare_in_period, clk, rst_n, out_valid,
        compare_a <= period_reg && compare_b <= period_reg && compare_c <= period_reg,
        "compare value beyond period")
    `SVPWM_ASSERT_IMPLY(a_sector_range, clk, rst_n, out_valid,
        sector <= 3'(SECTOR_COUNT - 1), "sector out of range")
    `SVPWM_ASSERT_ALWAYS_NEXT(a_reset_clears, clk, !rst_n, !out_valid,
        "result valid right after reset")

endmodule

bind space_vector_pwm_timing svpwm_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (compares.valid),
    .out_ready (compares.ready),
    .compare_a (compares.compare_a),
    .compare_b (compares.compare_b),
    .compare_c (compares.compare_c),
    .sector    (compares.sector),
    .saturated (compares.saturated)
);

`default_nettype wire
